// ===== rtl/core/cse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_pkg
// Types and constants shared by the cosine similarity engine modules.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int ELEM_WIDTH = 16;
  localparam int DIM_WIDTH  = 13;
  localparam int DOT_WIDTH  = 45;
  localparam int NORM_WIDTH = 44;
  localparam int PROD_WIDTH = 2 * NORM_WIDTH;
  localparam int ROOT_WIDTH = NORM_WIDTH;
  localparam int NUM_WIDTH  = DOT_WIDTH + 15;
  localparam int QUO_WIDTH  = 17;
  localparam int QDEPTH     = 4;
  localparam int QPTR_WIDTH = $clog2(QDEPTH);
  localparam int QCNT_WIDTH = $clog2(QDEPTH + 1);
  localparam int STEP_WIDTH = 6;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ZERO     = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic signed [ELEM_WIDTH-1:0] elem_a;
    logic signed [ELEM_WIDTH-1:0] elem_b;
    logic                         last;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0]          similarity;
    logic [1:0]                  status;
    logic [DIM_WIDTH-1:0]        dimension;
  } out_item_t;

  typedef struct packed {
    logic signed [DOT_WIDTH-1:0] dot;
    logic [NORM_WIDTH-1:0]       norm_a;
    logic [NORM_WIDTH-1:0]       norm_b;
    logic [DIM_WIDTH-1:0]        count;
    logic                        overflow;
  } job_t;

endpackage

// ===== rtl/core/cse_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_front
// Accepts element pairs, forms the three products and accumulates them.
// ----------------------------------------------------------------------------
module cse_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cse_pkg::in_item_t in_item,
  input  logic              room,
  output logic              push,
  output cse_pkg::job_t     push_job
);

  logic                                   s1_valid;
  cse_pkg::in_item_t                      s1_item;
  logic                                   s2_valid;
  logic                                   s2_last;
  logic signed [2*cse_pkg::ELEM_WIDTH-1:0] s2_ab;
  logic [2*cse_pkg::ELEM_WIDTH-2:0]       s2_aa;
  logic [2*cse_pkg::ELEM_WIDTH-2:0]       s2_bb;

  logic signed [cse_pkg::DOT_WIDTH-1:0]  dot;
  logic [cse_pkg::NORM_WIDTH-1:0]        norm_a;
  logic [cse_pkg::NORM_WIDTH-1:0]        norm_b;
  logic [cse_pkg::DIM_WIDTH-1:0]         count;
  logic                                  overflow;

  logic                                  take;
  cse_pkg::job_t                         job_next;

  assign in_ready = room;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid && in_ready;
      s2_valid <= s1_valid;
    end
    s1_item <= in_item;
    s2_last <= s1_item.last;
    s2_ab   <= s1_item.elem_a * s1_item.elem_b;
    s2_aa   <= (2*cse_pkg::ELEM_WIDTH-1)'(s1_item.elem_a * s1_item.elem_a);
    s2_bb   <= (2*cse_pkg::ELEM_WIDTH-1)'(s1_item.elem_b * s1_item.elem_b);
  end

  always_comb begin
    take = count < cse_pkg::DIM_WIDTH'(cse_pkg::MAX_DIM);
    job_next.dot      = dot;
    job_next.norm_a   = norm_a;
    job_next.norm_b   = norm_b;
    job_next.count    = count;
    job_next.overflow = overflow;
    if (take) begin
      job_next.dot    = dot + {{(cse_pkg::DOT_WIDTH-2*cse_pkg::ELEM_WIDTH)
                                 {s2_ab[2*cse_pkg::ELEM_WIDTH-1]}}, s2_ab};
      job_next.norm_a = norm_a + cse_pkg::NORM_WIDTH'(s2_aa);
      job_next.norm_b = norm_b + cse_pkg::NORM_WIDTH'(s2_bb);
      job_next.count  = count + 1'b1;
    end else begin
      job_next.overflow = 1'b1;
    end
  end

  assign push     = s2_valid && s2_last;
  assign push_job = job_next;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      dot      <= '0;
      norm_a   <= '0;
      norm_b   <= '0;
      count    <= '0;
      overflow <= 1'b0;
    end else if (s2_valid) begin
      dot      <= job_next.dot;
      norm_a   <= job_next.norm_a;
      norm_b   <= job_next.norm_b;
      count    <= job_next.count;
      overflow <= job_next.overflow;
    end
  end

endmodule

// ===== rtl/core/cse_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_queue
// Short queue of finished accumulations waiting for the back end.
// ----------------------------------------------------------------------------
module cse_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cse_pkg::job_t push_job,
  output logic          room,
  output logic          pop_valid,
  input  logic          pop,
  output cse_pkg::job_t pop_job
);

  cse_pkg::job_t                  slots [cse_pkg::QDEPTH];
  logic [cse_pkg::QPTR_WIDTH-1:0] wr_ptr;
  logic [cse_pkg::QPTR_WIDTH-1:0] rd_ptr;
  logic [cse_pkg::QCNT_WIDTH-1:0] fill;

  // Two results may still be in the product pipeline when ready is seen.
  assign room      = fill <= cse_pkg::QCNT_WIDTH'(cse_pkg::QDEPTH - 3);
  assign pop_valid = fill != '0;
  assign pop_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + cse_pkg::QCNT_WIDTH'(push) - cse_pkg::QCNT_WIDTH'(pop);
    end
    if (push) slots[wr_ptr] <= push_job;
  end

endmodule

// ===== rtl/core/cse_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_back
// Forms the norm product, its integer root and the scaled quotient, one step
// per cycle, unless a norm is zero, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module cse_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_pop,
  input  cse_pkg::job_t      job,
  output logic               out_valid,
  input  logic               out_ready,
  output cse_pkg::out_item_t out_item
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_SQRT = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t                          state;
  logic [cse_pkg::STEP_WIDTH-1:0]  step;
  logic [cse_pkg::PROD_WIDTH-1:0]  wide;
  logic [cse_pkg::PROD_WIDTH-1:0]  mcand;
  logic [cse_pkg::NORM_WIDTH-1:0]  mplier;
  logic [cse_pkg::PROD_WIDTH-1:0]  root;
  logic [cse_pkg::PROD_WIDTH-1:0]  one;
  logic [cse_pkg::NUM_WIDTH-1:0]   divisor;
  logic [cse_pkg::QUO_WIDTH-1:0]   quo;
  logic                            neg;
  logic [cse_pkg::DOT_WIDTH-1:0]   mag;
  logic [1:0]                      status;
  logic [cse_pkg::DIM_WIDTH-1:0]   dimension;
  logic                            zero_norm;

  logic [cse_pkg::PROD_WIDTH-1:0]  trial;
  logic                            trial_ok;
  logic                            div_ok;
  logic signed [15:0]              sim_next;

  assign job_pop = (state == ST_IDLE) && job_valid;

  always_comb begin
    trial    = root + one;
    trial_ok = wide >= trial;
    div_ok   = wide[cse_pkg::NUM_WIDTH-1:0] >= divisor;
    if (zero_norm) begin
      sim_next = '0;
    end else if (neg) begin
      sim_next = (quo > 17'd32768) ? -16'sd32768 : -$signed(quo[15:0]);
    end else begin
      sim_next = (quo > 17'd32767) ? 16'sd32767 : $signed(quo[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_FIN)) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            zero_norm <= (job.norm_a == '0) || (job.norm_b == '0);
            neg       <= job.dot[cse_pkg::DOT_WIDTH-1];
            mag       <= job.dot[cse_pkg::DOT_WIDTH-1] ? -job.dot : job.dot;
            dimension <= job.count;
            status    <= job.overflow ? cse_pkg::STATUS_OVERFLOW
                       : ((job.norm_a == '0) || (job.norm_b == '0)) ? cse_pkg::STATUS_ZERO
                       : cse_pkg::STATUS_OK;
            mcand     <= cse_pkg::PROD_WIDTH'(job.norm_a);
            mplier    <= job.norm_b;
            wide      <= '0;
            step      <= '0;
            state     <= ((job.norm_a == '0) || (job.norm_b == '0)) ? ST_FIN : ST_MUL;
          end
        end
        ST_MUL: begin
          if (mplier[0]) wide <= wide + mcand;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          step   <= step + 1'b1;
          if (step == cse_pkg::STEP_WIDTH'(cse_pkg::NORM_WIDTH - 1)) begin
            step  <= '0;
            root  <= '0;
            one   <= cse_pkg::PROD_WIDTH'(1) << (cse_pkg::PROD_WIDTH - 2);
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (trial_ok) begin
            wide <= wide - trial;
            root <= (root >> 1) + one;
          end else begin
            root <= root >> 1;
          end
          one  <= one >> 2;
          step <= step + 1'b1;
          if (step == cse_pkg::STEP_WIDTH'(cse_pkg::ROOT_WIDTH - 1)) begin
            step  <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step == '0) begin
            wide    <= cse_pkg::PROD_WIDTH'({mag, 15'd0});
            divisor <= cse_pkg::NUM_WIDTH'({root[cse_pkg::ROOT_WIDTH-1:0], 16'd0});
            quo     <= '0;
            step    <= step + 1'b1;
          end else begin
            if (div_ok) wide <= wide - cse_pkg::PROD_WIDTH'(divisor);
            quo     <= {quo[cse_pkg::QUO_WIDTH-2:0], div_ok};
            divisor <= divisor >> 1;
            step    <= step + 1'b1;
            if (step == cse_pkg::STEP_WIDTH'(cse_pkg::QUO_WIDTH)) begin
              step  <= '0;
              state <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid           <= 1'b1;
            out_item.similarity <= sim_next;
            out_item.status     <= status;
            out_item.dimension  <= dimension;
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/cosine_similarity_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_similarity_engine_top
// Streaming cosine similarity of two fixed-point vectors.
// ----------------------------------------------------------------------------
// Each input item carries one element pair in Q3.12 and a last flag. Pairs
// are taken one per cycle while input ready is high; a product pipeline of
// two stages feeds the accumulators. The item marked last closes the vector
// and its totals enter a four-entry queue. The back end then takes the
// totals, forms the shift-add norm product, the bit-pair square root and
// the quotient and loads the output register, and it overlaps with the
// accumulation of the next vector. An item whose norm is zero skips the
// arithmetic. One output item per vector gives similarity in Q1.15, a status
// and the pairs used. When the receiver stalls the result waits in the
// output register while the back end may finish the next one; when the
// queue holds more than one entry, input ready falls. Reset empties the
// pipeline and the queue and clears all accumulators.
// ----------------------------------------------------------------------------
module cosine_similarity_engine_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cse_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output cse_pkg::out_item_t out_item
);

  logic          room;
  logic          push;
  cse_pkg::job_t push_job;
  logic          pop_valid;
  logic          pop;
  cse_pkg::job_t pop_job;

  cse_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .room     (room),
    .push     (push),
    .push_job (push_job)
  );

  cse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .room      (room),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_job   (pop_job)
  );

  cse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (pop_valid),
    .job_pop   (pop),
    .job       (pop_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_item.status == cse_pkg::STATUS_OK)
                || (out_item.status == cse_pkg::STATUS_ZERO)
                || (out_item.status == cse_pkg::STATUS_OVERFLOW)))
    else $error("Result item carries an undefined status.");

  a_zero_sim: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status == cse_pkg::STATUS_ZERO) |-> (out_item.similarity == '0))
    else $error("Zero-norm result item has a nonzero similarity.");

  a_dim_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.dimension <= cse_pkg::DIM_WIDTH'(cse_pkg::MAX_DIM)))
    else $error("Result item reports more pairs than the maximum.");

  a_overflow_dim: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status == cse_pkg::STATUS_OVERFLOW)
      |-> (out_item.dimension == cse_pkg::DIM_WIDTH'(cse_pkg::MAX_DIM)))
    else $error("Overflow status without a full vector.");

endmodule

// ===== verif/tb_cosine_similarity_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cosine_similarity_engine_top
// Self-checking testbench for the streaming cosine similarity engine.
// ----------------------------------------------------------------------------
// A short table of directed vectors covers element extremes, zero norms, an
// empty-looking vector and rounding past one. Random vectors of mostly short
// length follow. Every accepted item feeds a behavioural model of the
// accumulators and the final root and divide; results are compared field by
// field in order. The sender works in bursts and the receiver stalls on its
// own pattern.
// ----------------------------------------------------------------------------
module tb_cosine_similarity_engine_top;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  cse_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cse_pkg::out_item_t out_item;

  cosine_similarity_engine_top uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .out_valid(out_valid), .out_ready(out_ready),
    .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic               last;
    logic               known;
    cse_pkg::out_item_t want;
  } row_t;

  longint             dot_sum;
  longint             norm_a_sum;
  longint             norm_b_sum;
  int                 pairs;
  bit                 too_many;
  cse_pkg::out_item_t expected_q[$];
  int                 errors = 0;

  function automatic logic [63:0] floor_root(logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if ({64'd0, c} * {64'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  function automatic cse_pkg::out_item_t similarity_of(input logic signed [15:0] a,
                                                       input logic signed [15:0] b,
                                                       input logic last,
                                                       output bit has);
    cse_pkg::out_item_t r;
    logic [127:0]       prod;
    logic [63:0]        root;
    logic [63:0]        mag;
    logic [63:0]        quo;
    has = 0;
    r = '0;
    if (pairs >= cse_pkg::MAX_DIM) begin
      too_many = 1;
    end else begin
      dot_sum    += longint'(a) * longint'(b);
      norm_a_sum += longint'(a) * longint'(a);
      norm_b_sum += longint'(b) * longint'(b);
      pairs++;
    end
    if (last) begin
      has = 1;
      r.status = cse_pkg::STATUS_OK;
      if (norm_a_sum == 0 || norm_b_sum == 0) begin
        r.status = cse_pkg::STATUS_ZERO;
        r.similarity = '0;
      end else begin
        prod = 128'(norm_a_sum) * 128'(norm_b_sum);
        root = floor_root(prod);
        mag = (dot_sum < 0) ? 64'(-dot_sum) : 64'(dot_sum);
        quo = (root != 0) ? ((mag << 15) / root) : 64'd0;
        if (dot_sum < 0) begin
          if (quo > 64'd32768) quo = 64'd32768;
          r.similarity = 16'((64'h10000 - quo) & 64'hFFFF);
        end else begin
          if (quo > 64'd32767) quo = 64'd32767;
          r.similarity = 16'(quo);
        end
      end
      if (too_many) r.status = cse_pkg::STATUS_OVERFLOW;
      r.dimension = 13'(pairs);
      dot_sum = 0; norm_a_sum = 0; norm_b_sum = 0; pairs = 0; too_many = 0;
    end
    return r;
  endfunction

  task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                           input logic last, input bit known,
                           input cse_pkg::out_item_t want);
    cse_pkg::out_item_t r;
    bit                 has;
    in_item.elem_a <= a;
    in_item.elem_b <= b;
    in_item.last   <= last;
    in_valid       <= 1'b1;
    do @(posedge clk); while (!in_ready);
    r = similarity_of(a, b, last, has);
    if (has) begin
      if (known && r != want) begin
        $error("table row: predicted %h differs from typed %h", r, want);
        errors++;
      end
      expected_q.push_back(r);
    end
    @(negedge clk);
    if ($urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic send_vector(input int len, input int mode);
    logic signed [15:0] a;
    logic signed [15:0] b;
    for (int i = 0; i < len; i++) begin
      a = 16'($urandom);
      b = 16'($urandom);
      if (mode == 1) b = a;
      else if (mode == 2) b = -a;
      else if (mode == 3) begin
        a = 16'($signed($urandom_range(0, 64)) - 32);
        b = 16'($signed($urandom_range(0, 64)) - 32);
      end
      send_pair(a, b, i == len - 1, 0, '0);
    end
  endtask

  row_t table_rows[] = '{
    '{16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1, '{16'sh7FFF, cse_pkg::STATUS_OK, 13'd1}},
    '{16'sh8000, 16'sh8000, 1'b1, 1'b1, '{16'sh7FFF, cse_pkg::STATUS_OK, 13'd1}},
    '{16'sh8000, 16'sh7FFF, 1'b1, 1'b1, '{16'sh8000, cse_pkg::STATUS_OK, 13'd1}},
    '{16'sh7FFF, 16'sh8000, 1'b1, 1'b1, '{16'sh8000, cse_pkg::STATUS_OK, 13'd1}},
    '{16'sh0000, 16'sh1000, 1'b1, 1'b1, '{16'sh0000, cse_pkg::STATUS_ZERO, 13'd1}},
    '{16'sh1000, 16'sh0000, 1'b1, 1'b1, '{16'sh0000, cse_pkg::STATUS_ZERO, 13'd1}},
    '{16'sh0000, 16'sh0000, 1'b1, 1'b1, '{16'sh0000, cse_pkg::STATUS_ZERO, 13'd1}},
    '{16'sh1000, 16'sh0000, 1'b0, 1'b0, '0},
    '{16'sh0000, 16'sh1000, 1'b1, 1'b0, '0},
    '{16'sh3000, 16'sh1000, 1'b0, 1'b0, '0},
    '{16'shD000, 16'sh2000, 1'b0, 1'b0, '0},
    '{16'sh0001, 16'shFFFF, 1'b1, 1'b0, '0},
    '{16'sh5555, 16'shAAAA, 1'b0, 1'b0, '0},
    '{16'shAAAA, 16'sh5555, 1'b1, 1'b0, '0},
    '{16'sh0001, 16'sh0001, 1'b1, 1'b1, '{16'sh7FFF, cse_pkg::STATUS_OK, 13'd1}}
  };

  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
  end

  always @(posedge clk) begin
    cse_pkg::out_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result %h", out_item);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_item.similarity !== e.similarity) begin
          $error("similarity: expected %0d actual %0d", e.similarity, out_item.similarity);
          errors++;
        end
        if (out_item.status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, out_item.status);
          errors++;
        end
        if (out_item.dimension !== e.dimension) begin
          $error("dimension: expected %0d actual %0d", e.dimension, out_item.dimension);
          errors++;
        end
      end
    end
  end

  initial begin
    int sent;
    int len;
    dot_sum = 0; norm_a_sum = 0; norm_b_sum = 0; pairs = 0; too_many = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (table_rows[i])
      send_pair(table_rows[i].a, table_rows[i].b, table_rows[i].last,
                table_rows[i].known, table_rows[i].want);
    sent = table_rows.size();
    while (sent < 1800) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      send_vector(len, $urandom_range(0, 3));
      sent += len;
    end
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== cosine_similarity_engine_top.f =====
rtl/core/cse_pkg.sv
rtl/core/cse_front.sv
rtl/core/cse_queue.sv
rtl/core/cse_back.sv
rtl/core/cosine_similarity_engine_top.sv
verif/tb_cosine_similarity_engine_top.sv
